### src/sacl_pkg.sv
// Package: shared types, sizes and codes of the set-associative LRU tag store.
package sacl_pkg;

  // Geometry
  localparam int unsigned MaxSetBits = 6;
  localparam int unsigned Ways       = 4;
  localparam int unsigned AddrW      = 64;

  localparam int unsigned NumSets = 1 << MaxSetBits;
  localparam int unsigned TagW    = AddrW - 2;
  localparam int unsigned RecW    = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned RefW    = RecW + 1;
  localparam int unsigned WayW    = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned NwW     = $clog2(Ways + 1);
  localparam int unsigned SetW    = MaxSetBits;

  // Port field widths
  localparam int unsigned ReqAddrW = 64;
  localparam int unsigned CntW     = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // Register reset values
  localparam logic [2:0] SetBitsRst   = 3'd4;
  localparam logic [5:0] BlockBitsRst = 6'd4;
  localparam logic [2:0] WaysRst      = 3'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_BLOCK_BITS  = 2'd1,
    REG_WAYS_IN_USE = 2'd2
  } sacl_reg_e;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_STORE  = 2'd1,
    REQ_MODIFY = 2'd2
  } sacl_req_e;

  // One way of a set as held in the tag memory
  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [RecW-1:0] rec;
  } sacl_line_t;

  typedef sacl_line_t [Ways-1:0] sacl_row_t;

  // Outcome of one lookup and update of a set
  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [Ways-1:0]  valid;
    sacl_row_t        row;
  } sacl_result_t;

endpackage

### src/sacl_if.sv
// Interfaces: request, result and configuration channels.
interface sacl_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic [sacl_pkg::ReqAddrW-1:0]     address;

  modport source(output valid, req_type, address, input ready);
  modport sink(input valid, req_type, address, output ready);
endinterface

interface sacl_res_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          evicted;
  logic [sacl_pkg::CntW-1:0]     hit_count;
  logic [sacl_pkg::CntW-1:0]     miss_count;
  logic [sacl_pkg::CntW-1:0]     evict_count;
  logic                          last;

  modport source(output valid, hit, evicted, hit_count, miss_count, evict_count, last,
                 input ready);
  modport sink(input valid, hit, evicted, hit_count, miss_count, evict_count, last,
               output ready);
endinterface

interface sacl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sacl_pkg::CfgIdxW-1:0]      reg_index;
  logic [sacl_pkg::CfgDataW-1:0]     wdata;

  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface

### src/sacl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sacl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/sacl_update.sv
// Set update: tag compare across ways, victim choice and LRU age update.
module sacl_update (
  input  sacl_pkg::sacl_row_t          row_i,
  input  logic [sacl_pkg::Ways-1:0]    valid_i,
  input  logic [sacl_pkg::TagW-1:0]    tag_i,
  input  logic [sacl_pkg::NwW-1:0]     nways_i,
  output sacl_pkg::sacl_result_t       res_o
);

  logic                          hit;
  logic [sacl_pkg::WayW-1:0]     hit_way;
  logic                          any_inv;
  logic [sacl_pkg::WayW-1:0]     inv_way;
  logic [sacl_pkg::WayW-1:0]     lru_way;
  logic [sacl_pkg::WayW-1:0]     victim;
  logic [sacl_pkg::RefW-1:0]     ref_age;

  // Lowest matching way, lowest free way, oldest way (lowest on ties)
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    lru_way = '0;
    for (int i = 0; i < sacl_pkg::Ways; i++) begin
      if (sacl_pkg::NwW'(i) < nways_i) begin
        if (!hit && valid_i[i] && (row_i[i].tag == tag_i)) begin
          hit     = 1'b1;
          hit_way = sacl_pkg::WayW'(i);
        end
        if (!any_inv && !valid_i[i]) begin
          any_inv = 1'b1;
          inv_way = sacl_pkg::WayW'(i);
        end
        if ((i > 0) && (row_i[i].rec > row_i[lru_way].rec)) begin
          lru_way = sacl_pkg::WayW'(i);
        end
      end
    end
  end

  assign victim = hit ? hit_way : (any_inv ? inv_way : lru_way);

  // Age of the touched way before the access; a free way counts as oldest of all
  assign ref_age = valid_i[victim] ? {1'b0, row_i[victim].rec}
                                   : sacl_pkg::RefW'(sacl_pkg::Ways);

  // Younger valid ways age by one, touched way becomes most recent
  always_comb begin
    res_o.hit     = hit;
    res_o.evicted = !hit && !any_inv;
    res_o.valid   = valid_i;
    res_o.row     = row_i;
    for (int i = 0; i < sacl_pkg::Ways; i++) begin
      if ((sacl_pkg::WayW'(i) != victim) && (sacl_pkg::NwW'(i) < nways_i) && valid_i[i] &&
          ({1'b0, row_i[i].rec} < ref_age) &&
          (row_i[i].rec < sacl_pkg::RecW'(sacl_pkg::Ways - 1))) begin
        res_o.row[i].rec = row_i[i].rec + 1'b1;
      end
    end
    res_o.row[victim].rec = '0;
    res_o.valid[victim]   = 1'b1;
    if (!hit) begin
      res_o.row[victim].tag = tag_i;
    end
  end

endmodule

### src/set_assoc_cache_lru_tag_store.sv
// Top level: set-associative cache tag store with true LRU replacement.
//
// Each request (load, store or modify) is split into set index and tag with the
// configured bit counts; each request reads the set's row (tags and ages of all
// ways) from one synchronous RAM, compares and updates it in the following cycle
// and writes it back. For a load or store, transfer starts the RAM read; the
// write-back of the row and the loading of the result into the output register
// follow together. A modify makes two accesses (its second access works on the
// forwarded row, no second read) and gives a result for each.
// The write-back waits while the output register holds a result not yet
// transferred. The next request is taken in the cycle after the last access of
// the previous one has been written back, even while that result still waits in
// the output register. Requests do not overlap. Line valid bits live in
// flip-flops cleared by reset, so the block is ready straight out of reset.
// Request type 3 is taken and dropped. Configuration is to be written only when
// idle, by the user; the block itself does not enforce this.
module set_assoc_cache_lru_tag_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  sacl_req_if.sink    req_i,
  sacl_res_if.source  res_o,
  sacl_cfg_if.sink    cfg_i
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [2:0] set_bits_q;
  logic [5:0] block_bits_q;
  logic [2:0] ways_q;

  logic [5:0]                    sb_eff;
  logic [5:0]                    bb_eff;
  logic [6:0]                    split_sh;
  logic [sacl_pkg::NwW-1:0]      nways;
  logic [sacl_pkg::AddrW-1:0]    addr_a;
  logic [sacl_pkg::AddrW-1:0]    addr_blk;
  logic [sacl_pkg::SetW-1:0]     set_mask;
  logic [sacl_pkg::SetW-1:0]     set_idx;
  logic [sacl_pkg::TagW-1:0]     tag_in;

  logic [sacl_pkg::SetW-1:0]     set_q;
  logic [sacl_pkg::TagW-1:0]     tag_q;
  logic [sacl_pkg::NwW-1:0]      nways_q;
  logic                          is_mod_q, second_q, fwd_q;
  logic                          second_d, fwd_d;
  sacl_pkg::sacl_row_t           row_fwd_q;

  logic [sacl_pkg::Ways-1:0]     valid_q [sacl_pkg::NumSets];

  logic                          req_xfer;
  logic                          req_real;
  logic                          ram_re;
  logic                          ram_we;
  sacl_pkg::sacl_row_t           ram_rdata;
  sacl_pkg::sacl_row_t           row_cur;
  sacl_pkg::sacl_result_t        res;

  logic [sacl_pkg::CntW-1:0]     hit_total_q, miss_total_q, evict_total_q;
  logic [sacl_pkg::CntW-1:0]     hit_total_d, miss_total_d, evict_total_d;

  logic                          out_valid_q;
  logic                          out_hit_q, out_ev_q, out_last_q;
  logic [sacl_pkg::CntW-1:0]     out_hc_q, out_mc_q, out_ec_q;
  logic                          out_free;

  // Configuration write port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= sacl_pkg::SetBitsRst;
      block_bits_q <= sacl_pkg::BlockBitsRst;
      ways_q       <= sacl_pkg::WaysRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        sacl_pkg::REG_SET_BITS:    set_bits_q   <= cfg_i.wdata[2:0];
        sacl_pkg::REG_BLOCK_BITS:  block_bits_q <= cfg_i.wdata[5:0];
        sacl_pkg::REG_WAYS_IN_USE: ways_q       <= cfg_i.wdata[2:0];
        default: ;
      endcase
    end
  end

  // Clamp registers into their meaningful ranges
  always_comb begin
    priority if (set_bits_q == 3'd0) sb_eff = 6'd1;
    else if ({3'b0, set_bits_q} > 6'(sacl_pkg::MaxSetBits)) sb_eff = 6'(sacl_pkg::MaxSetBits);
    else sb_eff = {3'b0, set_bits_q};

    priority if (block_bits_q == 6'd0) bb_eff = 6'd1;
    else if (block_bits_q > 6'd32) bb_eff = 6'd32;
    else bb_eff = block_bits_q;

    priority if (ways_q == 3'd0) nways = sacl_pkg::NwW'(1);
    else if ({3'b0, ways_q} > 6'(sacl_pkg::Ways)) nways = sacl_pkg::NwW'(sacl_pkg::Ways);
    else nways = sacl_pkg::NwW'(ways_q);
  end

  // Address split
  assign addr_a   = req_i.address[sacl_pkg::AddrW-1:0];
  assign addr_blk = addr_a >> bb_eff;
  assign set_mask = ~({sacl_pkg::SetW{1'b1}} << sb_eff);
  assign set_idx  = addr_blk[sacl_pkg::SetW-1:0] & set_mask;
  assign split_sh = {1'b0, sb_eff} + {1'b0, bb_eff};
  assign tag_in   = sacl_pkg::TagW'(addr_a >> split_sh);

  // Handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign req_real    = (req_i.req_type == sacl_pkg::REQ_LOAD) ||
                       (req_i.req_type == sacl_pkg::REQ_STORE) ||
                       (req_i.req_type == sacl_pkg::REQ_MODIFY);
  assign out_free    = !out_valid_q || res_o.ready;
  assign ram_re      = req_xfer && req_real;
  assign ram_we      = (state_q == S_LOOK) && out_free;

  // Tag and age memory, one row per set
  sacl_ram #(
    .Width($bits(sacl_pkg::sacl_row_t)),
    .Depth(sacl_pkg::NumSets)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(set_q),
    .wdata_i(res.row),
    .re_i   (ram_re),
    .raddr_i(set_idx),
    .rdata_o(ram_rdata)
  );

  // Second access of a modify works on the row just written
  assign row_cur = fwd_q ? row_fwd_q : ram_rdata;

  sacl_update u_update (
    .row_i  (row_cur),
    .valid_i(valid_q[set_q]),
    .tag_i  (tag_q),
    .nways_i(nways_q),
    .res_o  (res)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    fwd_d    = fwd_q;
    unique case (state_q)
      S_IDLE: begin
        if (ram_re) begin
          state_d  = S_LOOK;
          second_d = 1'b0;
          fwd_d    = 1'b0;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          if (is_mod_q && !second_q) begin
            second_d = 1'b1;
            fwd_d    = 1'b1;
          end else begin
            state_d  = S_IDLE;
            second_d = 1'b0;
            fwd_d    = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      second_q <= 1'b0;
      fwd_q    <= 1'b0;
      is_mod_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      fwd_q    <= fwd_d;
      if (ram_re) begin
        is_mod_q <= (req_i.req_type == sacl_pkg::REQ_MODIFY);
      end
    end
  end

  // Request fields latched at transfer, forwarded row latched at write-back
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      set_q   <= set_idx;
      tag_q   <= tag_in;
      nways_q <= nways;
    end
    if (ram_we) begin
      row_fwd_q <= res.row;
    end
  end

  // Line valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < sacl_pkg::NumSets; s++) begin
        valid_q[s] <= '0;
      end
    end else if (ram_we) begin
      valid_q[set_q] <= res.valid;
    end
  end

  // Saturating totals
  always_comb begin
    hit_total_d   = hit_total_q;
    miss_total_d  = miss_total_q;
    evict_total_d = evict_total_q;
    if (res.hit) begin
      if (hit_total_q != '1) hit_total_d = hit_total_q + 1'b1;
    end else begin
      if (miss_total_q != '1) miss_total_d = miss_total_q + 1'b1;
    end
    if (res.evicted && (evict_total_q != '1)) begin
      evict_total_d = evict_total_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_total_q   <= '0;
      miss_total_q  <= '0;
      evict_total_q <= '0;
    end else if (ram_we) begin
      hit_total_q   <= hit_total_d;
      miss_total_q  <= miss_total_d;
      evict_total_q <= evict_total_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ram_we) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      out_hit_q  <= res.hit;
      out_ev_q   <= res.evicted;
      out_hc_q   <= hit_total_d;
      out_mc_q   <= miss_total_d;
      out_ec_q   <= evict_total_d;
      out_last_q <= !is_mod_q || second_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.hit         = out_hit_q;
  assign res_o.evicted     = out_ev_q;
  assign res_o.hit_count   = out_hc_q;
  assign res_o.miss_count  = out_mc_q;
  assign res_o.evict_count = out_ec_q;
  assign res_o.last        = out_last_q;

`ifndef ASSERT_OFF
  // Forwarded row is only used by the second access of a modify
  a_fwd_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (state_q == S_LOOK) && second_q && is_mod_q)
    else $error("row forwarding outside the second access of a modify");

  // A write-back never overwrites a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!out_valid_q || res_o.ready))
    else $error("result register overwritten");

  // Hit and miss totals never go backwards
  a_miss_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (miss_total_q >= $past(miss_total_q)) && (hit_total_q >= $past(hit_total_q)))
    else $error("total decreased");

  // An eviction is always a miss and is counted as such
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && res.evicted) |-> !res.hit)
    else $error("eviction reported on a hit");
`endif

endmodule
